// ===== hw/rtl/ckmfb_pkg.sv =====
// shared types, codes and helpers for the color-keyed mono frame buffer
// no dependencies; imported by the front end, the back end and the top level
package ckmfb_pkg;

    localparam int POS_W      = 10;
    localparam int COLOR_W    = 8;
    localparam int DIM_W      = 10;
    localparam int ROT_W      = 2;
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int BIT_IDX_W  = 3;
    localparam int OUT_ADDR_W = 15;
    localparam int COUNT_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // pixel 0 of a byte sits in the msb
    localparam logic [BYTE_W-1:0] LEFT_PIXEL_MASK = 8'h80;

    // quarter turns
    localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

    localparam logic [DIM_W-1:0] PANEL_DIM_RESET = 10'd512;

    typedef enum logic [KIND_W-1:0] {
        OP_DRAW  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_RED      = 3'd0,
        REG_KEY_GREEN    = 3'd1,
        REG_KEY_BLUE     = 3'd2,
        REG_ROTATION     = 3'd3,
        REG_PANEL_WIDTH  = 3'd4,
        REG_PANEL_HEIGHT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0] key_red;
        logic [COLOR_W-1:0] key_green;
        logic [COLOR_W-1:0] key_blue;
        logic [ROT_W-1:0]   rotation;
        logic [DIM_W-1:0]   panel_width;
        logic [DIM_W-1:0]   panel_height;
    } cfg_t;

    // classified item, as it travels from the front to the back
    typedef struct packed {
        op_t                   op;
        logic                  on;
        logic                  hit;
        logic [BIT_IDX_W-1:0]  bit_idx;
        logic [OUT_ADDR_W-1:0] out_addr;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MODIFY
    } back_state_t;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (&c) ? c : c + COUNT_W'(1);
    endfunction

endpackage

// ===== hw/rtl/ckmfb_front.sv =====
// front end: accepts items, matches the key color, rotates and bounds checks,
// then forms the byte address and bit index; depends on ckmfb_pkg
module ckmfb_front #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int ADDR_W     = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ckmfb_pkg::cfg_t                   cfg,
    input  logic                              accept_en,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ckmfb_pkg::KIND_W-1:0]      in_kind,
    input  logic [ckmfb_pkg::POS_W-1:0]       in_pos_x,
    input  logic [ckmfb_pkg::POS_W-1:0]       in_pos_y,
    input  logic [ckmfb_pkg::COLOR_W-1:0]     in_red,
    input  logic [ckmfb_pkg::COLOR_W-1:0]     in_green,
    input  logic [ckmfb_pkg::COLOR_W-1:0]     in_blue,
    input  logic [ckmfb_pkg::OUT_ADDR_W-1:0]  in_read_address,
    output logic                              q_valid,
    input  logic                              q_ready,
    output ckmfb_pkg::cmd_t                   q_cmd,
    output logic [ADDR_W-1:0]                 q_addr
);
    import ckmfb_pkg::*;

    localparam int XW          = $clog2(MAX_WIDTH + 1);
    localparam int YW          = $clog2(MAX_HEIGHT + 1);
    localparam int DW0         = (XW > YW) ? XW : YW;
    localparam int DW          = (DW0 > POS_W + 1) ? DW0 : POS_W + 1;
    localparam int PW          = 2 * DW + 1;
    localparam int STRIDE_MAX  = (MAX_WIDTH + 7) / 8;
    localparam int STORE_BYTES = MAX_HEIGHT * STRIDE_MAX;
    localparam int RAW0        = (ADDR_W > OUT_ADDR_W) ? ADDR_W : OUT_ADDR_W;
    localparam int RAW         = RAW0 + 1;

    // stage 1: classify and rotate
    logic [DW-1:0] w_cfg, h_cfg, w, h, lw, lh, lx, ly, px, py;
    logic          inr, on;
    logic          load;

    logic                  s1_valid_reg, s1_valid_next;
    op_t                   s1_op_reg;
    logic                  s1_on_reg;
    logic                  s1_inr_reg;
    logic [DW-1:0]         s1_px_reg, s1_py_reg, s1_w_reg;
    logic [OUT_ADDR_W-1:0] s1_raddr_reg;

    always_comb begin
        w_cfg = DW'(cfg.panel_width);
        h_cfg = DW'(cfg.panel_height);
        w     = (w_cfg > DW'(MAX_WIDTH))  ? DW'(MAX_WIDTH)  : w_cfg;
        h     = (h_cfg > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : h_cfg;
        lw    = cfg.rotation[0] ? h : w;
        lh    = cfg.rotation[0] ? w : h;
        lx    = DW'(in_pos_x);
        ly    = DW'(in_pos_y);
        inr   = (lx < lw) && (ly < lh);
        on    = (in_red == cfg.key_red) && (in_green == cfg.key_green)
                && (in_blue == cfg.key_blue);
        case (cfg.rotation)
            ROT_90: begin
                px = w - DW'(1) - ly;
                py = lx;
            end
            ROT_180: begin
                px = w - DW'(1) - lx;
                py = h - DW'(1) - ly;
            end
            ROT_270: begin
                px = ly;
                py = h - DW'(1) - lx;
            end
            default: begin
                px = lx;
                py = ly;
            end
        endcase
    end

    assign in_ready = accept_en && (!s1_valid_reg || q_ready);
    assign load     = in_valid && in_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (load) begin
            s1_valid_next = 1'b1;
        end else if (q_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_op_reg    <= op_t'(in_kind);
            s1_on_reg    <= on;
            s1_inr_reg   <= inr;
            s1_px_reg    <= px;
            s1_py_reg    <= py;
            s1_w_reg     <= w;
            s1_raddr_reg <= in_read_address;
        end
    end

    // stage 2: byte address
    logic [DW-1:0]  stride;
    logic [PW-1:0]  pix_addr;
    logic [RAW-1:0] rd_ext;
    logic           pix_ok, rd_ok;

    always_comb begin
        stride   = (s1_w_reg + DW'(7)) >> 3;
        pix_addr = PW'(s1_py_reg) * PW'(stride) + PW'(s1_px_reg >> 3);
        pix_ok   = s1_inr_reg && (pix_addr < PW'(STORE_BYTES));
        rd_ext   = RAW'(s1_raddr_reg);
        rd_ok    = rd_ext < RAW'(STORE_BYTES);

        q_cmd.op       = s1_op_reg;
        q_cmd.bit_idx  = s1_px_reg[BIT_IDX_W-1:0];
        q_cmd.on       = 1'b0;
        q_cmd.hit      = 1'b0;
        q_cmd.out_addr = '0;
        q_addr         = '0;
        case (s1_op_reg)
            OP_DRAW: begin
                q_cmd.on  = s1_on_reg;
                q_cmd.hit = pix_ok;
                q_addr    = pix_addr[ADDR_W-1:0];
                if (pix_ok) begin
                    q_cmd.out_addr = pix_addr[OUT_ADDR_W-1:0];
                end
            end
            OP_READ: begin
                q_cmd.hit      = rd_ok;
                q_cmd.out_addr = s1_raddr_reg;
                q_addr         = rd_ext[ADDR_W-1:0];
            end
            default: begin
                q_cmd.hit = 1'b0;
            end
        endcase
    end

    assign q_valid = s1_valid_reg;

endmodule

// ===== hw/rtl/ckmfb_queue.sv =====
// two-entry fifo that decouples the front end from the store back end
// depends on ckmfb_pkg only by convention; payload is an opaque vector
module ckmfb_queue #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/ckmfb_back.sv =====
// back end: owns the byte store and the counters, does the read-modify-write,
// the clearing sweep and the result register; depends on ckmfb_pkg
module ckmfb_back #(
    parameter int STORE_BYTES = 32768,
    parameter int ADDR_W      = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    output logic                              init_done,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  ckmfb_pkg::cmd_t                   q_cmd,
    input  logic [ADDR_W-1:0]                 q_addr,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ckmfb_pkg::OUT_ADDR_W-1:0]  m_byte_address,
    output logic [ckmfb_pkg::BYTE_W-1:0]      m_byte_value,
    output logic                              m_wrote,
    output logic                              m_pixel_on,
    output logic [ckmfb_pkg::COUNT_W-1:0]     m_set_total,
    output logic [ckmfb_pkg::COUNT_W-1:0]     m_unset_total
);
    import ckmfb_pkg::*;

    logic [BYTE_W-1:0] store_mem [STORE_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              reply_reg, reply_next;
    logic              init_reg, init_next;
    cmd_t              cur_reg, cur_next;
    logic [COUNT_W-1:0] set_reg, set_next, unset_reg, unset_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_ADDR_W-1:0] addr_out_reg, addr_out_next;
    logic [BYTE_W-1:0]     value_reg, value_next;
    logic                  wrote_reg, wrote_next;
    logic                  on_reg, on_next;
    logic [COUNT_W-1:0]    set_out_reg, set_out_next, unset_out_reg, unset_out_next;

    logic              out_free, pop, sweep_last, load_out;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [BYTE_W-1:0] mem_wd, mask;

    assign out_free   = !m_valid_reg || m_ready;
    assign pop        = (state_reg == ST_IDLE) && q_valid && out_free;
    assign sweep_last = sweep_reg == ADDR_W'(STORE_BYTES - 1);
    assign mask       = LEFT_PIXEL_MASK >> cur_reg.bit_idx;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    if (q_cmd.op == OP_CLEAR) begin
                        state_next = ST_SWEEP;
                    end else if (q_cmd.hit) begin
                        state_next = ST_MODIFY;
                    end
                end
            end
            ST_MODIFY: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        sweep_next     = sweep_reg;
        reply_next     = reply_reg;
        init_next      = init_reg;
        cur_next       = cur_reg;
        set_next       = set_reg;
        unset_next     = unset_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wa         = sweep_reg;
        mem_ra         = q_addr;
        mem_wd         = '0;
        load_out       = 1'b0;
        addr_out_next  = '0;
        value_next     = '0;
        wrote_next     = 1'b0;
        on_next        = 1'b0;
        q_ready        = pop;

        case (state_reg)
            ST_SWEEP: begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_last) begin
                    sweep_next = '0;
                    init_next  = 1'b1;
                    reply_next = 1'b0;
                    load_out   = reply_reg;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    cur_next = q_cmd;
                    case (q_cmd.op)
                        OP_DRAW: begin
                            if (q_cmd.on) begin
                                set_next = bump(set_reg);
                            end else begin
                                unset_next = bump(unset_reg);
                            end
                            if (q_cmd.hit) begin
                                mem_re = 1'b1;
                            end else begin
                                load_out = 1'b1;
                                on_next  = q_cmd.on;
                            end
                        end
                        OP_READ: begin
                            if (q_cmd.hit) begin
                                mem_re = 1'b1;
                            end else begin
                                load_out      = 1'b1;
                                addr_out_next = q_cmd.out_addr;
                            end
                        end
                        OP_CLEAR: begin
                            set_next   = '0;
                            unset_next = '0;
                            reply_next = 1'b1;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_MODIFY: begin
                load_out      = 1'b1;
                addr_out_next = cur_reg.out_addr;
                if (cur_reg.op == OP_DRAW) begin
                    mem_we     = 1'b1;
                    mem_wa     = sweep_reg;
                    mem_wd     = cur_reg.on ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
                    value_next = mem_wd;
                    wrote_next = 1'b1;
                    on_next    = cur_reg.on;
                end else begin
                    value_next = rd_data_reg;
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase

        set_out_next   = set_next;
        unset_out_next = unset_next;
        m_valid_next   = load_out ? 1'b1 : (m_valid_reg && !m_ready);
    end

    // the modify step writes back where the pop cycle read; reuse sweep_reg's
    // port only during sweep, otherwise take the held address
    logic [ADDR_W-1:0] cur_addr_reg;
    logic [ADDR_W-1:0] wr_addr;

    assign wr_addr = (state_reg == ST_MODIFY) ? cur_addr_reg : mem_wa;

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_addr_reg <= q_addr;
        end
        if (mem_we) begin
            store_mem[wr_addr] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            sweep_reg   <= '0;
            reply_reg   <= 1'b0;
            init_reg    <= 1'b0;
            set_reg     <= '0;
            unset_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            reply_reg   <= reply_next;
            init_reg    <= init_next;
            set_reg     <= set_next;
            unset_reg   <= unset_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (load_out) begin
            addr_out_reg  <= addr_out_next;
            value_reg     <= value_next;
            wrote_reg     <= wrote_next;
            on_reg        <= on_next;
            set_out_reg   <= set_out_next;
            unset_out_reg <= unset_out_next;
        end
    end

    assign init_done      = init_reg;
    assign m_valid        = m_valid_reg;
    assign m_byte_address = addr_out_reg;
    assign m_byte_value   = value_reg;
    assign m_wrote        = wrote_reg;
    assign m_pixel_on     = on_reg;
    assign m_set_total    = set_out_reg;
    assign m_unset_total  = unset_out_reg;

endmodule

// ===== hw/rtl/color_keyed_mono_framebuffer.sv =====
// Color-keyed 1-bit-per-pixel frame buffer. Each draw beat carries a logical
// pixel position and an RGB color; a color equal to the key sets the pixel bit,
// any other color clears it, after the position is rotated by 0/90/180/270
// degrees and bounds checked against the rotated panel size. The store holds
// MAX_HEIGHT rows of ceil(MAX_WIDTH/8) bytes, msb = leftmost pixel, with a row
// stride of ceil(panel_width/8). Read beats return one stored byte, clear beats
// zero the store and the two saturating 20-bit pixel counters. Every input beat
// gives exactly one result beat. A two-stage front end (color match and
// rotation, then address multiply) feeds a two-entry queue, so input beats keep
// flowing while the back end is busy, until the queue fills. The back end owns
// the single-port byte store: an in-range draw or read is a read step, then a
// modify/write step; any other beat is a single step, and a clear walks every
// store byte. After reset the back end runs the same clearing pass and s_ready
// stays low until it is done; configuration writes are taken at any time and
// are meant for idle periods.
// Depends on ckmfb_pkg, ckmfb_front, ckmfb_queue and ckmfb_back.
module color_keyed_mono_framebuffer #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ckmfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ckmfb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ckmfb_pkg::KIND_W-1:0]      s_kind,
    input  logic [ckmfb_pkg::POS_W-1:0]       s_pos_x,
    input  logic [ckmfb_pkg::POS_W-1:0]       s_pos_y,
    input  logic [ckmfb_pkg::COLOR_W-1:0]     s_red,
    input  logic [ckmfb_pkg::COLOR_W-1:0]     s_green,
    input  logic [ckmfb_pkg::COLOR_W-1:0]     s_blue,
    input  logic [ckmfb_pkg::OUT_ADDR_W-1:0]  s_read_address,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ckmfb_pkg::OUT_ADDR_W-1:0]  m_byte_address,
    output logic [ckmfb_pkg::BYTE_W-1:0]      m_byte_value,
    output logic                              m_wrote,
    output logic                              m_pixel_on,
    output logic [ckmfb_pkg::COUNT_W-1:0]     m_set_total,
    output logic [ckmfb_pkg::COUNT_W-1:0]     m_unset_total
);
    import ckmfb_pkg::*;

    localparam int STRIDE_MAX  = (MAX_WIDTH + 7) / 8;
    localparam int STORE_BYTES = MAX_HEIGHT * STRIDE_MAX;
    localparam int ADDR_W0     = $clog2(STORE_BYTES);
    localparam int ADDR_W      = (ADDR_W0 > 0) ? ADDR_W0 : 1;
    localparam int Q_W         = $bits(cmd_t) + ADDR_W;

    // configuration registers, always writable
    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KEY_RED:      cfg_next.key_red      = cfg_data[COLOR_W-1:0];
                REG_KEY_GREEN:    cfg_next.key_green    = cfg_data[COLOR_W-1:0];
                REG_KEY_BLUE:     cfg_next.key_blue     = cfg_data[COLOR_W-1:0];
                REG_ROTATION:     cfg_next.rotation     = cfg_data[ROT_W-1:0];
                REG_PANEL_WIDTH:  cfg_next.panel_width  = cfg_data[DIM_W-1:0];
                REG_PANEL_HEIGHT: cfg_next.panel_height = cfg_data[DIM_W-1:0];
                default:          cfg_next = cfg_reg;  // unknown index is dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_red      <= '0;
            cfg_reg.key_green    <= '0;
            cfg_reg.key_blue     <= '0;
            cfg_reg.rotation     <= ROT_NONE;
            cfg_reg.panel_width  <= PANEL_DIM_RESET;
            cfg_reg.panel_height <= PANEL_DIM_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end to queue
    logic              init_done;
    logic              f_valid, f_ready;
    cmd_t              f_cmd;
    logic [ADDR_W-1:0] f_addr;

    ckmfb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .accept_en       (init_done),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_kind         (s_kind),
        .in_pos_x        (s_pos_x),
        .in_pos_y        (s_pos_y),
        .in_red          (s_red),
        .in_green        (s_green),
        .in_blue         (s_blue),
        .in_read_address (s_read_address),
        .q_valid         (f_valid),
        .q_ready         (f_ready),
        .q_cmd           (f_cmd),
        .q_addr          (f_addr)
    );

    // queue between the two halves
    logic [Q_W-1:0]    q_in, q_out;
    logic              b_valid, b_ready;
    cmd_t              b_cmd;
    logic [ADDR_W-1:0] b_addr;

    assign q_in            = {f_cmd, f_addr};
    assign {b_cmd, b_addr} = q_out;

    ckmfb_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    // back end: store, counters, result register
    ckmfb_back #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .init_done      (init_done),
        .q_valid        (b_valid),
        .q_ready        (b_ready),
        .q_cmd          (b_cmd),
        .q_addr         (b_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_address (m_byte_address),
        .m_byte_value   (m_byte_value),
        .m_wrote        (m_wrote),
        .m_pixel_on     (m_pixel_on),
        .m_set_total    (m_set_total),
        .m_unset_total  (m_unset_total)
    );

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // a matching pixel has been counted by the time its result shows
    a_on_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pixel_on |-> m_set_total != '0)
        else $error("pixel_on result with zero set total");

    // a stored non-matching pixel has been counted too
    a_off_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wrote && !m_pixel_on |-> m_unset_total != '0)
        else $error("cleared pixel result with zero unset total");

    // no input beat is taken during the clearing pass after reset
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_ready)
        else $error("input accepted before store was cleared");

endmodule

// ===== tb/color_keyed_mono_framebuffer_tb.sv =====
// self-checking testbench for the color-keyed mono frame buffer: a directed table, then
// randomized phases with register changes, checked beat by beat against a shadow frame store
// depends on ckmfb_pkg and color_keyed_mono_framebuffer
module color_keyed_mono_framebuffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ckmfb_pkg::*;

    localparam int MAX_W = 512;
    localparam int MAX_H = 512;
    localparam int FRAME_BYTES = MAX_H * ((MAX_W + 7) / 8);
    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
    // indexes past the last register, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] FIRST_UNMAPPED_REG = 3'd6;

    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 175;
    localparam int MAX_CLEARS      = 10;     // each clear walks the whole store
    localparam int PRESSURE_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 64;
    // well above a full clearing pass plus the longest stall
    localparam int WATCHDOG_LIMIT  = 150000;

    typedef struct packed {
        op_t                   kind;
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_y;
        logic [COLOR_W-1:0]    red;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    blue;
        logic [OUT_ADDR_W-1:0] read_address;
    } beat_t;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0]     byte_value;
        logic                  wrote;
        logic                  pixel_on;
        logic [COUNT_W-1:0]    set_total;
        logic [COUNT_W-1:0]    unset_total;
    } report_t;

    // one line of the directed table: a register write or a pixel beat
    typedef struct packed {
        bit                     is_reg;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        beat_t                  beat;
        bit                     has_want;
        report_t                want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [KIND_W-1:0]     s_kind;
    logic [POS_W-1:0]      s_pos_x;
    logic [POS_W-1:0]      s_pos_y;
    logic [COLOR_W-1:0]    s_red;
    logic [COLOR_W-1:0]    s_green;
    logic [COLOR_W-1:0]    s_blue;
    logic [OUT_ADDR_W-1:0] s_read_address;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_ADDR_W-1:0] m_byte_address;
    logic [BYTE_W-1:0]     m_byte_value;
    logic                  m_wrote;
    logic                  m_pixel_on;
    logic [COUNT_W-1:0]    m_set_total;
    logic [COUNT_W-1:0]    m_unset_total;

    // shadow copy of the block's state and registers
    logic [BYTE_W-1:0]  shadow_frame [FRAME_BYTES];
    logic [COUNT_W-1:0] lit_count;
    logic [COUNT_W-1:0] dark_count;
    cfg_t               shadow_cfg;

    // result beats still owed by the block, oldest first
    report_t byte_reports_q [$];

    int unsigned fail_count   = 0;
    bit          idling_on    = 1'b1;
    bit          hold_req     = 1'b0;   // sender asks the sink for one long hold-off
    bit          sink_holding = 1'b0;   // sink is in that hold-off, sender keeps pushing

    color_keyed_mono_framebuffer #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_read_address(s_read_address),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_address(m_byte_address),
        .m_byte_value  (m_byte_value),
        .m_wrote       (m_wrote),
        .m_pixel_on    (m_pixel_on),
        .m_set_total   (m_set_total),
        .m_unset_total (m_unset_total)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // draw, read or clear one beat on the shadow state and work out the result beat
    function automatic report_t paint_pixel_beat(input beat_t b);
        report_t     r;
        int unsigned w, h, lw, lh, px, py, line_bytes, idx;
        logic [BYTE_W-1:0] mask;
        r = '0;
        case (b.kind)
            OP_DRAW: begin
                w  = (shadow_cfg.panel_width > MAX_W) ? MAX_W : shadow_cfg.panel_width;
                h  = (shadow_cfg.panel_height > MAX_H) ? MAX_H : shadow_cfg.panel_height;
                // odd quarter turns swap the logical width and height
                lw = shadow_cfg.rotation[0] ? h : w;
                lh = shadow_cfg.rotation[0] ? w : h;
                r.pixel_on = (b.red == shadow_cfg.key_red) && (b.green == shadow_cfg.key_green)
                             && (b.blue == shadow_cfg.key_blue);
                // counters move whether or not the pixel lands
                if (r.pixel_on) begin
                    if (lit_count != COUNT_SAT) lit_count = lit_count + 1'b1;
                end else if (dark_count != COUNT_SAT) begin
                    dark_count = dark_count + 1'b1;
                end
                if (b.pos_x < lw && b.pos_y < lh) begin
                    case (shadow_cfg.rotation)
                        ROT_90: begin
                            px = w - 1 - b.pos_y;
                            py = b.pos_x;
                        end
                        ROT_180: begin
                            px = w - 1 - b.pos_x;
                            py = h - 1 - b.pos_y;
                        end
                        ROT_270: begin
                            px = b.pos_y;
                            py = h - 1 - b.pos_x;
                        end
                        default: begin
                            px = b.pos_x;
                            py = b.pos_y;
                        end
                    endcase
                    line_bytes = (w + 7) / 8;
                    idx = px / 8 + py * line_bytes;
                    if (idx < FRAME_BYTES) begin
                        mask = LEFT_PIXEL_MASK >> (px % 8);
                        if (r.pixel_on) shadow_frame[idx] = shadow_frame[idx] | mask;
                        else            shadow_frame[idx] = shadow_frame[idx] & ~mask;
                        r.byte_address = OUT_ADDR_W'(idx);
                        r.byte_value   = shadow_frame[idx];
                        r.wrote        = 1'b1;
                    end
                end
            end
            OP_READ: begin
                r.byte_address = b.read_address;
                r.byte_value   = (b.read_address < FRAME_BYTES) ? shadow_frame[b.read_address]
                                                                : '0;
            end
            OP_CLEAR: begin
                foreach (shadow_frame[i]) shadow_frame[i] = '0;
                lit_count  = '0;
                dark_count = '0;
            end
            default: ;  // spare kind leaves everything alone
        endcase
        r.set_total   = lit_count;
        r.unset_total = dark_count;
        return r;
    endfunction

    function automatic stim_row_t item_row(input op_t k, input int x, input int y,
                                           input int rd, input int gr, input int bl,
                                           input int ra);
        stim_row_t s;
        s = '0;
        s.beat.kind         = k;
        s.beat.pos_x        = POS_W'(x);
        s.beat.pos_y        = POS_W'(y);
        s.beat.red          = COLOR_W'(rd);
        s.beat.green        = COLOR_W'(gr);
        s.beat.blue         = COLOR_W'(bl);
        s.beat.read_address = OUT_ADDR_W'(ra);
        return s;
    endfunction

    function automatic stim_row_t pinned(input stim_row_t s, input report_t want);
        stim_row_t t;
        t = s;
        t.has_want = 1'b1;
        t.want     = want;
        return t;
    endfunction

    function automatic stim_row_t cfg_row(input reg_idx_t idx, input int val);
        stim_row_t s;
        s = '0;
        s.is_reg    = 1'b1;
        s.reg_index = idx;
        s.reg_data  = CFG_DATA_W'(val);
        return s;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return DIM_W'($urandom_range(513, 1023));  // saturates to the maximum
            2, 3:    return DIM_W'(MAX_W);
            default: return DIM_W'($urandom_range(1, 64));
        endcase
    endfunction

    // offer one pixel beat, hold it until taken, then log what it should produce
    task automatic send_item(input beat_t b, input bit use_want, input report_t want);
        report_t predicted;
        if (idling_on && !sink_holding && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= b.kind;
        s_pos_x        <= b.pos_x;
        s_pos_y        <= b.pos_y;
        s_red          <= b.red;
        s_green        <= b.green;
        s_blue         <= b.blue;
        s_read_address <= b.read_address;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        predicted = paint_pixel_beat(b);
        byte_reports_q.push_back(use_want ? want : predicted);
    endtask

    // cfg_valid is left high so back-to-back writes follow each other without a gap; caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        case (idx)
            REG_KEY_RED:      shadow_cfg.key_red      = data[COLOR_W-1:0];
            REG_KEY_GREEN:    shadow_cfg.key_green    = data[COLOR_W-1:0];
            REG_KEY_BLUE:     shadow_cfg.key_blue     = data[COLOR_W-1:0];
            REG_ROTATION:     shadow_cfg.rotation     = data[ROT_W-1:0];
            REG_PANEL_WIDTH:  shadow_cfg.panel_width  = data[DIM_W-1:0];
            REG_PANEL_HEIGHT: shadow_cfg.panel_height = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    // stop offering beats and let every owed result come back before touching registers
    task automatic settle();
        s_valid <= 1'b0;
        while (byte_reports_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result sink: checks every taken beat and throttles m_ready
    initial begin : result_sink
        int unsigned hold_left;
        report_t     got;
        report_t     want;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_byte_address, m_byte_value, m_wrote, m_pixel_on,
                       m_set_total, m_unset_total};
                if (byte_reports_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result beat with nothing owed: addr %0d byte %02h",
                                 got.byte_address, got.byte_value);
                end else begin
                    want = byte_reports_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch want: addr %0d byte %02h wrote %0b on %0b set %0d unset %0d",
                                     want.byte_address, want.byte_value, want.wrote,
                                     want.pixel_on, want.set_total, want.unset_total);
                            $display("          got: addr %0d byte %02h wrote %0b on %0b set %0d unset %0d",
                                     got.byte_address, got.byte_value, got.wrote,
                                     got.pixel_on, got.set_total, got.unset_total);
                        end
                    end
                end
            end
            // next cycle's ready
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                sink_holding = 1'b0;
                if (hold_req) begin
                    // long back-pressure so the queue fills and s_ready drops
                    hold_req     = 1'b0;
                    sink_holding = 1'b1;
                    hold_left    = PRESSURE_CYCLES - 1;
                    m_ready <= 1'b0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    hold_left = $urandom_range(0, 12);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // any beat on any channel keeps the run alive
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        stim_row_t   rows [$];
        reg_idx_t    key_regs [3];
        beat_t       b;
        bit          prev_was_reg;
        int unsigned w_eff, h_eff, lw, lh, region, clears_sent, roll, kv;

        key_regs = '{REG_KEY_RED, REG_KEY_GREEN, REG_KEY_BLUE};

        // every input known from time zero
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_kind         <= OP_DRAW;
        s_pos_x        <= '0;
        s_pos_y        <= '0;
        s_red          <= '0;
        s_green        <= '0;
        s_blue         <= '0;
        s_read_address <= '0;

        // shadow state after reset
        foreach (shadow_frame[i]) shadow_frame[i] = '0;
        lit_count  = '0;
        dark_count = '0;
        shadow_cfg = '0;
        shadow_cfg.rotation     = ROT_NONE;
        shadow_cfg.panel_width  = PANEL_DIM_RESET;
        shadow_cfg.panel_height = PANEL_DIM_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table; reset key is black, 512x512, no rotation, 64-byte stride
        rows.push_back(pinned(item_row(OP_READ, 0, 0, 0, 0, 0, 0),
                              {15'd0, 8'h00, 1'b0, 1'b0, 20'd0, 20'd0}));
        // top-left pixel lands in the msb of byte 0
        rows.push_back(pinned(item_row(OP_DRAW, 0, 0, 0, 0, 0, 0),
                              {15'd0, 8'h80, 1'b1, 1'b1, 20'd1, 20'd0}));
        // bottom-right corner, last byte of the store
        rows.push_back(pinned(item_row(OP_DRAW, 511, 511, 255, 255, 255, 0),
                              {15'd32767, 8'h00, 1'b1, 1'b0, 20'd1, 20'd1}));
        // out of range: counted but nothing stored
        rows.push_back(pinned(item_row(OP_DRAW, 1023, 1023, 0, 0, 0, 0),
                              {15'd0, 8'h00, 1'b0, 1'b1, 20'd2, 20'd1}));
        rows.push_back(pinned(item_row(OP_DRAW, 512, 0, 255, 0, 0, 0),
                              {15'd0, 8'h00, 1'b0, 1'b0, 20'd2, 20'd2}));
        // rightmost pixel of a byte is the lsb
        rows.push_back(pinned(item_row(OP_DRAW, 7, 0, 0, 0, 0, 0),
                              {15'd0, 8'h81, 1'b1, 1'b1, 20'd3, 20'd2}));
        // non-key color clears a set bit
        rows.push_back(pinned(item_row(OP_DRAW, 0, 0, 0, 255, 0, 0),
                              {15'd0, 8'h01, 1'b1, 1'b0, 20'd3, 20'd3}));
        rows.push_back(pinned(item_row(OP_READ, 0, 0, 0, 0, 0, 32767),
                              {15'd32767, 8'h00, 1'b0, 1'b0, 20'd3, 20'd3}));
        rows.push_back(item_row(OP_READ, 0, 0, 0, 0, 0, 15'h2aaa));
        // spare kind answers like a clear but keeps the counters
        rows.push_back(pinned(item_row(OP_NOP, 1023, 1023, 255, 255, 255, 32767),
                              {15'd0, 8'h00, 1'b0, 1'b0, 20'd3, 20'd3}));
        // one lsb off the key
        rows.push_back(item_row(OP_DRAW, 0, 511, 0, 0, 1, 0));
        // odd key, quarter turn on a 100x40 panel (logical 40x100)
        rows.push_back(cfg_row(REG_KEY_RED, 255));
        rows.push_back(cfg_row(REG_KEY_GREEN, 128));
        rows.push_back(cfg_row(REG_KEY_BLUE, 1));
        rows.push_back(cfg_row(REG_ROTATION, ROT_90));
        rows.push_back(cfg_row(REG_PANEL_WIDTH, 100));
        rows.push_back(cfg_row(REG_PANEL_HEIGHT, 40));
        rows.push_back(item_row(OP_DRAW, 39, 99, 255, 128, 1, 0));
        rows.push_back(item_row(OP_DRAW, 40, 0, 255, 128, 1, 0));
        rows.push_back(item_row(OP_DRAW, 0, 100, 0, 128, 1, 0));
        rows.push_back(cfg_row(REG_ROTATION, ROT_180));
        rows.push_back(item_row(OP_DRAW, 0, 0, 255, 128, 1, 0));
        rows.push_back(item_row(OP_DRAW, 99, 39, 255, 255, 255, 0));
        rows.push_back(cfg_row(REG_ROTATION, ROT_270));
        rows.push_back(item_row(OP_DRAW, 39, 99, 255, 128, 1, 0));
        rows.push_back(item_row(OP_DRAW, 0, 0, 255, 128, 1, 0));
        // zero width: nothing ever in range
        rows.push_back(cfg_row(REG_PANEL_WIDTH, 0));
        rows.push_back(item_row(OP_DRAW, 0, 0, 255, 128, 1, 0));
        // oversized panel saturates to the maximum
        rows.push_back(cfg_row(REG_PANEL_WIDTH, 1023));
        rows.push_back(cfg_row(REG_PANEL_HEIGHT, 1023));
        rows.push_back(cfg_row(REG_ROTATION, ROT_NONE));
        rows.push_back(item_row(OP_DRAW, 511, 511, 255, 128, 1, 0));
        rows.push_back(item_row(OP_DRAW, 512, 0, 255, 128, 1, 0));
        rows.push_back(pinned(item_row(OP_CLEAR, 0, 0, 0, 0, 0, 0),
                              {15'd0, 8'h00, 1'b0, 1'b0, 20'd0, 20'd0}));
        rows.push_back(pinned(item_row(OP_READ, 0, 0, 0, 0, 0, 507),
                              {15'd507, 8'h00, 1'b0, 1'b0, 20'd0, 20'd0}));
        // smallest panel
        rows.push_back(cfg_row(REG_PANEL_WIDTH, 1));
        rows.push_back(cfg_row(REG_PANEL_HEIGHT, 1));
        rows.push_back(item_row(OP_DRAW, 0, 0, 255, 128, 1, 0));
        rows.push_back(item_row(OP_DRAW, 0, 1, 255, 128, 1, 0));

        prev_was_reg = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].is_reg) begin
                if (!prev_was_reg) settle();
                write_reg(rows[i].reg_index, rows[i].reg_data);
            end else begin
                if (prev_was_reg) cfg_valid <= 1'b0;
                send_item(rows[i].beat, rows[i].has_want, rows[i].want);
            end
            prev_was_reg = rows[i].is_reg;
        end

        // random phases, each under a fresh register setting
        clears_sent = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            foreach (key_regs[k]) begin
                roll = $urandom_range(0, 3);
                kv = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(0, 255);
                // upper data bits must be dropped by the register
                if ($urandom_range(0, 7) == 0) kv = kv | ($urandom_range(1, 3) << 8);
                write_reg(key_regs[k], CFG_DATA_W'(kv));
            end
            kv = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0) kv = kv | ($urandom_range(1, 255) << 2);
            write_reg(REG_ROTATION, CFG_DATA_W'(kv));
            case (phase)
                1: begin
                    write_reg(REG_PANEL_WIDTH, DIM_W'(MAX_W));
                    write_reg(REG_PANEL_HEIGHT, DIM_W'(MAX_H));
                end
                2: begin
                    write_reg(REG_PANEL_WIDTH, DIM_W'(1023));
                    write_reg(REG_PANEL_HEIGHT, DIM_W'(1));
                end
                3: begin
                    write_reg(REG_PANEL_WIDTH, DIM_W'(1));
                    write_reg(REG_PANEL_HEIGHT, DIM_W'(1023));
                end
                default: begin
                    write_reg(REG_PANEL_WIDTH, pick_dim());
                    write_reg(REG_PANEL_HEIGHT, pick_dim());
                end
            endcase
            write_reg(FIRST_UNMAPPED_REG + CFG_IDX_W'($urandom_range(0, 1)),
                      CFG_DATA_W'($urandom_range(0, 1023)));
            cfg_valid <= 1'b0;

            // last phase runs with both sides flat out
            idling_on = (phase != PHASES - 1);

            w_eff  = (shadow_cfg.panel_width > MAX_W) ? MAX_W : shadow_cfg.panel_width;
            h_eff  = (shadow_cfg.panel_height > MAX_H) ? MAX_H : shadow_cfg.panel_height;
            lw     = shadow_cfg.rotation[0] ? h_eff : w_eff;
            lh     = shadow_cfg.rotation[0] ? w_eff : h_eff;
            region = ((w_eff + 7) / 8) * h_eff;

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (phase == 1 && n == 40) hold_req = 1'b1;

                // mostly draws; clears are rare since each one sweeps the store
                roll = $urandom_range(0, 199);
                if (roll < 140)      b.kind = OP_DRAW;
                else if (roll < 185) b.kind = OP_READ;
                else if (roll < 198) b.kind = OP_NOP;
                else if (clears_sent < MAX_CLEARS) begin
                    b.kind = OP_CLEAR;
                    clears_sent++;
                end else             b.kind = OP_DRAW;

                // positions mostly inside the logical panel, the rest anywhere
                if (lw != 0 && lh != 0 && $urandom_range(0, 99) < 85) begin
                    b.pos_x = POS_W'($urandom_range(0, lw - 1));
                    b.pos_y = POS_W'($urandom_range(0, lh - 1));
                end else begin
                    b.pos_x = POS_W'($urandom_range(0, 1023));
                    b.pos_y = POS_W'($urandom_range(0, 1023));
                end

                // key color, near miss by one bit, or anything
                roll = $urandom_range(0, 9);
                if (roll < 7) begin
                    b.red   = shadow_cfg.key_red;
                    b.green = shadow_cfg.key_green;
                    b.blue  = shadow_cfg.key_blue;
                    if (roll >= 5) begin
                        case ($urandom_range(0, 2))
                            0:       b.red   = b.red ^ (8'h01 << $urandom_range(0, 7));
                            1:       b.green = b.green ^ (8'h01 << $urandom_range(0, 7));
                            default: b.blue  = b.blue ^ (8'h01 << $urandom_range(0, 7));
                        endcase
                    end
                end else begin
                    b.red   = COLOR_W'($urandom_range(0, 255));
                    b.green = COLOR_W'($urandom_range(0, 255));
                    b.blue  = COLOR_W'($urandom_range(0, 255));
                end

                // reads mostly inside the bytes this panel can touch
                if (region != 0 && $urandom_range(0, 9) < 7)
                    b.read_address = OUT_ADDR_W'($urandom_range(0, region - 1));
                else
                    b.read_address = OUT_ADDR_W'($urandom_range(0, FRAME_BYTES - 1));

                send_item(b, 1'b0, '0);
            end
        end

        // drain, then give the block a little longer to misbehave
        s_valid <= 1'b0;
        while (byte_reports_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        fail_count += byte_reports_q.size();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== color_keyed_mono_framebuffer.f =====
hw/rtl/ckmfb_pkg.sv
hw/rtl/ckmfb_front.sv
hw/rtl/ckmfb_queue.sv
hw/rtl/ckmfb_back.sv
hw/rtl/color_keyed_mono_framebuffer.sv
tb/color_keyed_mono_framebuffer_tb.sv
